/* rtl/core/token_ring_termination_detector_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the token ring termination detector
// Shared concurrent check forms, clocked on the rising edge and disabled
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TOKEN_RING_TERMINATION_DETECTOR_UNIT_DEFINES_SVH
`define TOKEN_RING_TERMINATION_DETECTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("token ring termination detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("token ring termination detector: next-cycle check failed");

`endif

/* rtl/core/trtd_pkg.sv */
// ----------------------------------------------------------------------------
// Token ring termination detector package
// Command and message codes, register indexes and the records passed
// between the front end, the descriptor queue and the result generator.
// ----------------------------------------------------------------------------
package trtd_pkg;

	typedef enum logic [2:0] {
		CMD_THREAD_PASSIVE = 3'd0,
		CMD_THREAD_ACTIVE  = 3'd1,
		CMD_TOKEN_IN       = 3'd2,
		CMD_SEND_TOKEN     = 3'd3,
		CMD_TERM_IN        = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MSG_NONE  = 2'd0,
		MSG_TOKEN = 2'd1,
		MSG_TERM  = 2'd2
	} msg_kind_t;

	localparam logic [1:0] REG_NODE_ID      = 2'd0;
	localparam logic [1:0] REG_NODE_COUNT   = 2'd1;
	localparam logic [1:0] REG_THREAD_COUNT = 2'd2;

	// Descriptor queue depth; kept a power of two so the pointers wrap freely.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] worker_id;
		logic       token_state;
		logic [5:0] token_initiator;
		logic [5:0] token_receiver;
	} item_t;

	typedef struct packed {
		logic       wr;
		logic [1:0] idx;
		logic [31:0] data;
	} cfg_wr_t;

	typedef struct packed {
		msg_kind_t  kind;
		logic [5:0] dest;
		logic       ts;
		logic [5:0] init;
		logic       acc;
		logic [5:0] last_idx;
		logic       term;
		logic       np;
		logic       tp;
	} desc_t;

	typedef struct packed {
		msg_kind_t  kind;
		logic [5:0] dest;
		logic       ts;
		logic [5:0] init;
		logic       acc;
		logic       term;
		logic       np;
		logic       tp;
		logic       last;
	} res_t;

endpackage

/* rtl/core/trtd_fifo.sv */
// ----------------------------------------------------------------------------
// Descriptor queue
// Short show-ahead queue between the front end and the result generator.
// ----------------------------------------------------------------------------
module trtd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  trtd_pkg::desc_t wdata,
	output logic           full,
	input  logic           pop,
	output trtd_pkg::desc_t head,
	output logic           head_valid
);
	import trtd_pkg::*;

	desc_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (cnt_q == (QAW + 1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QAW + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QAW + 1)'(1);
			end
		end
	end

endmodule

/* rtl/core/trtd_front.sv */
// ----------------------------------------------------------------------------
// Front end of the termination detector
// Holds the configuration and node state, applies each accepted event and
// turns it into one message descriptor for the result generator.
// ----------------------------------------------------------------------------
module trtd_front #(
	parameter int MAX_THREADS = 16,
	parameter int MAX_NODES   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  trtd_pkg::item_t   item,
	output logic              full,
	input  logic              q_full,
	output logic              q_push,
	output trtd_pkg::desc_t   q_data,
	input  trtd_pkg::cfg_wr_t cfg_wr,
	input  logic [1:0]        cfg_raddr,
	output logic [31:0]       cfg_rdata
);
	import trtd_pkg::*;

	localparam int ATW = $clog2(MAX_THREADS + 1);

	logic [5:0]             node_id_q;
	logic [6:0]             node_count_q;
	logic [4:0]             thread_count_q;
	logic [MAX_THREADS-1:0] pass_bits_q;
	logic [ATW-1:0]         active_cnt_q;
	logic                   node_state_q;
	logic                   sticky_q;
	logic                   master_q;
	logic                   term_q;
	logic [6:0]             rem_q;

	logic [ATW-1:0]         eff_threads;
	logic [6:0]             eff_nodes;
	logic                   succ_busy;
	logic                   accept;
	logic [MAX_THREADS-1:0] sel;
	logic                   in_range;
	logic                   cur_bit;

	logic [MAX_THREADS-1:0] n_bits;
	logic [ATW-1:0]         n_act;
	logic                   n_ns;
	logic                   n_sticky;
	logic                   n_master;
	logic                   n_term;
	desc_t                  d;

	function automatic logic [ATW-1:0] sat_threads(input logic [4:0] v);
		logic [6:0] w;
		w = {2'b00, v};
		if (w == 7'd0) begin
			return ATW'(1);
		end else if (w > 7'(MAX_THREADS)) begin
			return ATW'(MAX_THREADS);
		end
		return ATW'(w);
	endfunction

	always_comb begin
		if (node_count_q == 7'd0) begin
			eff_nodes = 7'd1;
		end else if (node_count_q > 7'(MAX_NODES)) begin
			eff_nodes = 7'(MAX_NODES);
		end else begin
			eff_nodes = node_count_q;
		end
	end

	assign eff_threads = sat_threads(thread_count_q);

	// The ring successor is reduced by repeated subtraction after a write.
	assign succ_busy = (rem_q >= eff_nodes);
	assign full      = q_full || succ_busy;
	assign accept    = push && !full;

	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++) begin
			sel[i] = ({3'b000, item.worker_id} == 7'(i));
		end
	end

	assign in_range = ({3'b000, item.worker_id} < 7'(eff_threads));
	assign cur_bit  = in_range && |(pass_bits_q & sel);

	always_comb begin
		n_bits   = pass_bits_q;
		n_act    = active_cnt_q;
		n_ns     = node_state_q;
		n_sticky = sticky_q;
		n_master = master_q;
		n_term   = term_q;
		d        = '0;
		d.kind   = MSG_NONE;
		unique case (item.cmd)
			CMD_THREAD_PASSIVE: begin
				if (in_range && !cur_bit) begin
					n_bits = pass_bits_q | sel;
					n_act  = (active_cnt_q != '0) ? active_cnt_q - ATW'(1) : '0;
					if (n_act == '0) begin
						n_ns = 1'b1;
					end
				end
			end
			CMD_THREAD_ACTIVE: begin
				if (in_range && cur_bit) begin
					n_bits   = pass_bits_q & ~sel;
					n_act    = active_cnt_q + ATW'(1);
					n_ns     = 1'b0;
					n_sticky = 1'b0;
				end
			end
			CMD_TOKEN_IN: begin
				n_master = 1'b1;
				if (sticky_q && (item.token_receiver == item.token_initiator)) begin
					if (item.token_state) begin
						d.kind     = MSG_TERM;
						d.last_idx = 6'(eff_nodes - 7'd1);
					end
				end else if (sticky_q) begin
					n_master = 1'b0;
					d.kind   = MSG_TOKEN;
					d.dest   = rem_q[5:0];
					d.ts     = item.token_state;
					d.init   = item.token_initiator;
				end
				n_sticky = node_state_q;
			end
			CMD_SEND_TOKEN: begin
				if (master_q) begin
					n_master = 1'b0;
					d.kind   = MSG_TOKEN;
					d.dest   = rem_q[5:0];
					d.ts     = item.token_state;
					d.init   = item.token_initiator;
					d.acc    = 1'b1;
				end
			end
			CMD_TERM_IN: begin
				n_term = 1'b1;
			end
			default: begin
			end
		endcase
		d.term = n_term;
		d.np   = n_ns;
		d.tp   = in_range && |(n_bits & sel);
	end

	assign q_push = accept;
	assign q_data = d;

	always_comb begin
		unique case (cfg_raddr)
			REG_NODE_ID:      cfg_rdata = {26'd0, node_id_q};
			REG_NODE_COUNT:   cfg_rdata = {25'd0, node_count_q};
			REG_THREAD_COUNT: cfg_rdata = {27'd0, thread_count_q};
			default:          cfg_rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q      <= '0;
			node_count_q   <= 7'd1;
			thread_count_q <= 5'd1;
			pass_bits_q    <= '0;
			active_cnt_q   <= sat_threads(5'd1);
			node_state_q   <= 1'b0;
			sticky_q       <= 1'b0;
			master_q       <= 1'b1;
			term_q         <= 1'b0;
			rem_q          <= '0;
		end else begin
			if (cfg_wr.wr && (cfg_wr.idx == REG_NODE_ID)) begin
				rem_q <= {1'b0, cfg_wr.data[5:0]} + 7'd1;
			end else if (cfg_wr.wr && (cfg_wr.idx == REG_NODE_COUNT)) begin
				rem_q <= {1'b0, node_id_q} + 7'd1;
			end else if (succ_busy) begin
				rem_q <= rem_q - eff_nodes;
			end

			if (cfg_wr.wr) begin
				unique case (cfg_wr.idx)
					REG_NODE_ID: begin
						node_id_q <= cfg_wr.data[5:0];
						master_q  <= (cfg_wr.data[5:0] == 6'd0);
					end
					REG_NODE_COUNT: begin
						node_count_q <= cfg_wr.data[6:0];
					end
					REG_THREAD_COUNT: begin
						thread_count_q <= cfg_wr.data[4:0];
						pass_bits_q    <= '0;
						active_cnt_q   <= sat_threads(cfg_wr.data[4:0]);
						node_state_q   <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				pass_bits_q  <= n_bits;
				active_cnt_q <= n_act;
				node_state_q <= n_ns;
				sticky_q     <= n_sticky;
				master_q     <= n_master;
				term_q       <= n_term;
			end
		end
	end

endmodule

/* rtl/core/trtd_back.sv */
// ----------------------------------------------------------------------------
// Result generator of the termination detector
// Expands each descriptor into its result rows, one per cycle while the
// output is popped or empty, into a registered output stage.
// ----------------------------------------------------------------------------
module trtd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  trtd_pkg::desc_t head,
	input  logic            head_valid,
	output logic            head_pop,
	output trtd_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_pop
);
	import trtd_pkg::*;

	logic [5:0] idx_q;
	logic       valid_q;
	res_t       res_q;
	res_t       row;
	logic       load;
	logic       is_bcast;
	logic       row_last;

	assign load     = head_valid && (!valid_q || res_pop);
	assign is_bcast = (head.kind == MSG_TERM);
	assign row_last = !is_bcast || (idx_q == head.last_idx);
	assign head_pop = load && row_last;

	always_comb begin
		row.kind = head.kind;
		row.dest = is_bcast ? idx_q : head.dest;
		row.ts   = head.ts;
		row.init = head.init;
		row.acc  = head.acc;
		row.term = head.term;
		row.np   = head.np;
		row.tp   = head.tp;
		row.last = row_last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= row_last ? 6'd0 : idx_q + 6'd1;
				valid_q <= 1'b1;
			end else if (res_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = valid_q;

endmodule

/* rtl/core/token_ring_termination_detector_unit.sv */
// ----------------------------------------------------------------------------
// Token ring termination detector, one node
// One event accepted per cycle while full is low: the four-entry descriptor
// queue has room and the ring successor is not being reduced, which follows
// a node_id or node_count write. An event reaches the result ports via the
// queue and the output register. A terminator broadcast gives node-count
// results, one per cycle while popped. Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
`include "token_ring_termination_detector_unit_defines.svh"

// The front end owns all node state. At the edge at which an event is
// accepted it updates the thread passive bits, the active count, the node,
// sticky, master and terminate flags, and writes one descriptor into a short
// queue. The descriptor already carries the status fields as they stand after
// the whole event, so the result generator never looks back at the state.
//
// The result generator takes the oldest descriptor and emits its rows into a
// registered output stage. A token or a status row is a single transaction;
// a terminator broadcast is one transaction per node on the ring, addressed
// to nodes zero upwards, with last set on the final one. The queue lets the
// front end keep accepting events while a long broadcast drains.
//
// After reset the node has id zero, one node on the ring and one thread in
// use; it is master, every thread is active and nothing is terminated.
module token_ring_termination_detector_unit #(
	parameter int MAX_THREADS = 16,
	parameter int MAX_NODES   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [3:0]  worker_id,
	input  logic        token_state,
	input  logic [5:0]  token_initiator,
	input  logic [5:0]  token_receiver,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  msg_kind,
	output logic [5:0]  dest_node,
	output logic        out_token_state,
	output logic [5:0]  out_initiator,
	output logic        send_accepted,
	output logic        terminate_flag,
	output logic        node_passive,
	output logic        thread_passive,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import trtd_pkg::*;

	item_t   item;
	cfg_wr_t cfg_wr;
	desc_t   q_wdata;
	desc_t   q_head;
	logic    q_push;
	logic    q_full;
	logic    q_valid;
	logic    q_pop;
	res_t    res;
	logic    res_valid;

	// The register port never waits, so a write lands on its access cycle.
	assign pready = 1'b1;

	assign cfg_wr.wr   = psel && penable && pwrite && pready;
	assign cfg_wr.idx  = paddr[3:2];
	assign cfg_wr.data = pwdata;

	assign item.cmd             = cmd;
	assign item.worker_id       = worker_id;
	assign item.token_state     = token_state;
	assign item.token_initiator = token_initiator;
	assign item.token_receiver  = token_receiver;

	trtd_front #(
		.MAX_THREADS(MAX_THREADS),
		.MAX_NODES  (MAX_NODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.cfg_wr   (cfg_wr),
		.cfg_raddr(paddr[3:2]),
		.cfg_rdata(prdata)
	);

	trtd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.head_valid(q_valid)
	);

	trtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.head_valid(q_valid),
		.head_pop  (q_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	// Result ports are driven straight from the registered output stage.
	assign empty           = !res_valid;
	assign msg_kind        = res.kind;
	assign dest_node       = res.dest;
	assign out_token_state = res.ts;
	assign out_initiator   = res.init;
	assign send_accepted   = res.acc;
	assign terminate_flag  = res.term;
	assign node_passive    = res.np;
	assign thread_passive  = res.tp;
	assign last            = res.last;

	// Only a broadcast spans several result transactions.
	`TRTD_ASSERT_IMP(a_multi_row_is_broadcast, clk, arst_n, !empty && !last, msg_kind == MSG_TERM)
	// Within a broadcast the next row follows at once, addressed to the next node.
	`TRTD_ASSERT_NXT(a_broadcast_steps, clk, arst_n, !empty && pop && !last, !empty && (dest_node == ($past(dest_node) + 6'd1)))
	// An honoured send request always produces a token.
	`TRTD_ASSERT_IMP(a_send_is_token, clk, arst_n, !empty && send_accepted, msg_kind == MSG_TOKEN && last)

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the token ring termination detector unit
// Events are pushed into the detector and a predictor tracks the node state
// alongside it. Every result transaction is checked field by field against
// the oldest prediction. A short directed part is followed by rounds of
// well-formed termination sequences mixed with noise, spread over several
// register settings that include the saturation extremes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trtd_pkg::*;

	// The command field has room for three codes that the detector does not use.
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	localparam int THREAD_LIMIT  = 16;
	localparam int RING_LIMIT    = 64;
	localparam int RANDOM_EVENTS = 300;
	localparam int PHASE_EVENTS  = 50;

	// The slowest correct run: about 400 events, each one a 64-node broadcast
	// with every result behind the longest stall, plus the longest sender gap.
	// The limit sits well above that.
	localparam int CYCLE_LIMIT = 4_000_000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  cmd;
	logic [3:0]  worker_id;
	logic        token_state;
	logic [5:0]  token_initiator;
	logic [5:0]  token_receiver;
	logic        empty;
	logic        pop;
	logic [1:0]  msg_kind;
	logic [5:0]  dest_node;
	logic        out_token_state;
	logic [5:0]  out_initiator;
	logic        send_accepted;
	logic        terminate_flag;
	logic        node_passive;
	logic        thread_passive;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	token_ring_termination_detector_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.cmd             (cmd),
		.worker_id       (worker_id),
		.token_state     (token_state),
		.token_initiator (token_initiator),
		.token_receiver  (token_receiver),
		.empty           (empty),
		.pop             (pop),
		.msg_kind        (msg_kind),
		.dest_node       (dest_node),
		.out_token_state (out_token_state),
		.out_initiator   (out_initiator),
		.send_accepted   (send_accepted),
		.terminate_flag  (terminate_flag),
		.node_passive    (node_passive),
		.thread_passive  (thread_passive),
		.last            (last),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	// ------------------------------------------------------------------------
	// Predicted node state. This mirrors the registers and the termination
	// bookkeeping of the detector, updated at the edge at which an event
	// transaction or a register write completes.
	// ------------------------------------------------------------------------
	logic [5:0]  cfg_node_id;
	logic [6:0]  cfg_node_count;
	logic [4:0]  cfg_thread_count;
	logic [15:0] passive_mask;
	logic [4:0]  active_threads;
	logic        node_idle;
	logic        sticky_idle;
	logic        holds_token;
	logic        terminated_seen;

	// Messages still owed by the detector, oldest first.
	res_t expected_msgs[$];

	int unsigned errors;
	int unsigned cycle_count;
	int unsigned events_sent;
	int unsigned counted_events;
	int unsigned results_checked;
	int unsigned broadcasts_seen;
	int unsigned settings_used;
	bit          quiet;

	// Thread and node counts are used saturated to the supported range.
	function automatic int unsigned used_threads();
		if (cfg_thread_count == 0)
			return 1;
		if (cfg_thread_count > THREAD_LIMIT)
			return THREAD_LIMIT;
		return cfg_thread_count;
	endfunction

	function automatic int unsigned ring_size();
		if (cfg_node_count == 0)
			return 1;
		if (cfg_node_count > RING_LIMIT)
			return RING_LIMIT;
		return cfg_node_count;
	endfunction

	// Writing the thread count wakes every thread and makes the node active.
	function automatic void wake_all_threads();
		passive_mask   = '0;
		active_threads = 5'(used_threads());
		node_idle      = 1'b0;
	endfunction

	// Applies one event to the predicted state and queues the messages that
	// it causes. Returns zero for an event the detector merely ignores: an
	// unused command, or a thread command that names a thread out of use.
	function automatic bit predict_messages(item_t ev);
		int unsigned threads;
		int unsigned nodes;
		int unsigned succ_node;
		int unsigned first;
		int unsigned k;
		bit          counts;
		res_t        row;

		threads   = used_threads();
		nodes     = ring_size();
		succ_node = (cfg_node_id + 1) % nodes;
		first     = expected_msgs.size();
		counts    = 1'b1;
		row       = '0;
		row.kind  = MSG_NONE;

		case (ev.cmd)
			CMD_THREAD_PASSIVE: begin
				if (ev.worker_id < threads) begin
					if (!passive_mask[ev.worker_id]) begin
						passive_mask[ev.worker_id] = 1'b1;
						if (active_threads > 0)
							active_threads--;
						if (active_threads == 0)
							node_idle = 1'b1;
					end
				end else begin
					counts = 1'b0;
				end
			end
			CMD_THREAD_ACTIVE: begin
				if (ev.worker_id < threads) begin
					if (passive_mask[ev.worker_id]) begin
						passive_mask[ev.worker_id] = 1'b0;
						active_threads++;
						node_idle   = 1'b0;
						sticky_idle = 1'b0;
					end
				end else begin
					counts = 1'b0;
				end
			end
			CMD_TOKEN_IN: begin
				holds_token = 1'b1;
				if (sticky_idle && ev.token_receiver == ev.token_initiator) begin
					// A passive token back at its initiator ends the computation;
					// an active one is simply held here.
					if (ev.token_state) begin
						for (k = 0; k < nodes; k++) begin
							row      = '0;
							row.kind = MSG_TERM;
							row.dest = 6'(k);
							expected_msgs.push_back(row);
						end
					end
				end else if (sticky_idle) begin
					holds_token = 1'b0;
					row         = '0;
					row.kind    = MSG_TOKEN;
					row.dest    = 6'(succ_node);
					row.ts      = ev.token_state;
					row.init    = ev.token_initiator;
					expected_msgs.push_back(row);
				end
				sticky_idle = node_idle;
			end
			CMD_SEND_TOKEN: begin
				if (holds_token) begin
					holds_token = 1'b0;
					row         = '0;
					row.kind    = MSG_TOKEN;
					row.dest    = 6'(succ_node);
					row.ts      = ev.token_state;
					row.init    = ev.token_initiator;
					row.acc     = 1'b1;
					expected_msgs.push_back(row);
				end
			end
			CMD_TERM_IN: begin
				terminated_seen = 1'b1;
			end
			default: begin
				counts = 1'b0;
			end
		endcase

		// Every event that sends nothing still reports its status once.
		if (expected_msgs.size() == first) begin
			row      = '0;
			row.kind = MSG_NONE;
			expected_msgs.push_back(row);
		end

		// Status fields show the state after the whole event.
		for (k = first; k < expected_msgs.size(); k++) begin
			row      = expected_msgs[k];
			row.term = terminated_seen;
			row.np   = node_idle;
			row.tp   = (ev.worker_id < threads) ? passive_mask[ev.worker_id] : 1'b0;
			row.last = (k == expected_msgs.size() - 1);
			expected_msgs[k] = row;
		end
		return counts;
	endfunction

	// Idle lengths: mostly none or short, now and then long. During quiet
	// stretches neither side idles at all.
	function automatic int unsigned gap_len();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Clock, cycle limit and idle pattern.
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Quiet stretches come and go so that back-to-back traffic is seen on
	// both sides as well as the ragged kind.
	initial begin
		quiet = 1'b0;
		forever begin
			repeat ($urandom_range(100, 600)) @(posedge clk);
			quiet = ~quiet;
		end
	end

	// The result side pops for one cycle and then stalls for a random time.
	initial begin : result_pacing
		int unsigned hold;
		hold = 0;
		pop  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop  <= 1'b1;
				hold = gap_len();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checking. A result transaction completes at a rising edge with
	// pop high and empty low; the values seen here are those from before the
	// edge, so they belong to that transaction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (msg_kind == MSG_TERM && last)
				broadcasts_seen++;
			if (expected_msgs.size() == 0) begin
				$error("unexpected result transaction: msg_kind %0d, dest_node %0d",
					msg_kind, dest_node);
				errors++;
			end else begin
				want = expected_msgs.pop_front();
				check_field("msg_kind", want.kind, msg_kind);
				check_field("dest_node", want.dest, dest_node);
				check_field("out_token_state", want.ts, out_token_state);
				check_field("out_initiator", want.init, out_initiator);
				check_field("send_accepted", want.acc, send_accepted);
				check_field("terminate_flag", want.term, terminate_flag);
				check_field("node_passive", want.np, node_passive);
				check_field("thread_passive", want.tp, thread_passive);
				check_field("last", want.last, last);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Event side. An event is offered after a random gap and held until the
	// detector takes it. push is left high on return so that the next event
	// can follow at once without push being dropped in between.
	// ------------------------------------------------------------------------
	task automatic send_item(logic [2:0] op, logic [3:0] tid, logic ts,
			logic [5:0] init, logic [5:0] recv);
		int unsigned idle;
		item_t       ev;
		idle = gap_len();
		if (idle > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		push            <= 1'b1;
		cmd             <= op;
		worker_id       <= tid;
		token_state     <= ts;
		token_initiator <= init;
		token_receiver  <= recv;
		do
			@(posedge clk);
		while (full);
		ev.cmd             = op;
		ev.worker_id       = tid;
		ev.token_state     = ts;
		ev.token_initiator = init;
		ev.token_receiver  = recv;
		events_sent++;
		if (predict_messages(ev))
			counted_events++;
	endtask

	// Stops offering events and waits until every owed result has come out,
	// plus a short margin for the detector to settle.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write followed by a read back of the same register.
	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		logic [31:0] mask;
		case (idx)
			REG_NODE_ID:    mask = 32'h3f;
			REG_NODE_COUNT: mask = 32'h7f;
			default:        mask = 32'h1f;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_NODE_ID: begin
				cfg_node_id = value[5:0];
				holds_token = (value[5:0] == 0);
			end
			REG_NODE_COUNT: begin
				cfg_node_count = value[6:0];
			end
			default: begin
				cfg_thread_count = value[4:0];
				wake_all_threads();
			end
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== (value & mask)) begin
			$error("prdata mismatch at register %0d: expected %0d, got %0d",
				idx, value & mask, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(logic [5:0] id, logic [6:0] nodes, logic [4:0] threads);
		drain();
		write_register(REG_NODE_ID, 32'(id));
		write_register(REG_NODE_COUNT, 32'(nodes));
		write_register(REG_THREAD_COUNT, 32'(threads));
		settings_used++;
	endtask

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------

	// Reset state: node zero on a ring of one with a single thread. The spare
	// command codes must change nothing; the first send is honoured because
	// node zero starts as master, the second is refused.
	task automatic test_spare_codes_and_send();
		send_item(CMD_SPARE_A, 4'd3, 1'b0, 6'd0, 6'd0);
		send_item(CMD_SPARE_B, 4'd0, 1'b1, 6'd63, 6'd0);
		send_item(CMD_SPARE_C, 4'd15, 1'b1, 6'd63, 6'd63);
		send_item(CMD_SEND_TOKEN, 4'd0, 1'b1, 6'd63, 6'd0);
		send_item(CMD_SEND_TOKEN, 4'd0, 1'b0, 6'd0, 6'd63);
	endtask

	// A thread outside the count in use is ignored; repeating a state change
	// is harmless.
	task automatic test_thread_activity();
		send_item(CMD_THREAD_PASSIVE, 4'd15, 1'b0, 6'd0, 6'd0);
		send_item(CMD_THREAD_PASSIVE, 4'd0, 1'b0, 6'd0, 6'd0);
		send_item(CMD_THREAD_PASSIVE, 4'd0, 1'b1, 6'd63, 6'd63);
	endtask

	// With the node passive: the first token is kept while the sticky state
	// catches up, an active token at its initiator is held, a passive one
	// triggers the broadcast, and a token for another round is forwarded.
	// Waking a thread clears the sticky state; the terminator sets the flag.
	task automatic test_token_handling();
		send_item(CMD_TOKEN_IN, 4'd0, 1'b1, 6'd63, 6'd0);
		send_item(CMD_TOKEN_IN, 4'd0, 1'b0, 6'd7, 6'd7);
		send_item(CMD_TOKEN_IN, 4'd0, 1'b1, 6'd63, 6'd63);
		send_item(CMD_TOKEN_IN, 4'd0, 1'b0, 6'd0, 6'd63);
		send_item(CMD_SEND_TOKEN, 4'd0, 1'b1, 6'd5, 6'd0);
		send_item(CMD_THREAD_ACTIVE, 4'd0, 1'b0, 6'd0, 6'd0);
		send_item(CMD_THREAD_ACTIVE, 4'd0, 1'b0, 6'd0, 6'd0);
		send_item(CMD_THREAD_ACTIVE, 4'd9, 1'b0, 6'd0, 6'd0);
		send_item(CMD_TERM_IN, 4'd0, 1'b0, 6'd0, 6'd0);
	endtask

	// Last node on the widest ring: the node count saturates, the successor
	// wraps to node zero and a terminator goes out to all 64 nodes.
	task automatic test_wide_ring();
		configure(6'd63, 7'd127, 5'd0);
		send_item(CMD_SEND_TOKEN, 4'd0, 1'b1, 6'd1, 6'd0);
		send_item(CMD_THREAD_PASSIVE, 4'd0, 1'b0, 6'd0, 6'd0);
		send_item(CMD_TOKEN_IN, 4'd0, 1'b1, 6'd0, 6'd1);
		send_item(CMD_TOKEN_IN, 4'd0, 1'b1, 6'd0, 6'd0);
		send_item(CMD_SEND_TOKEN, 4'd0, 1'b1, 6'd42, 6'd0);
		send_item(CMD_TOKEN_IN, 4'd0, 1'b1, 6'd5, 6'd6);
	endtask

	// ------------------------------------------------------------------------
	// Random part.
	// ------------------------------------------------------------------------

	// One termination round: the threads go passive (sometimes only some of
	// them), tokens arrive with random content and mostly passive state,
	// and now and then a send, a terminator or a wake-up follows.
	task automatic run_round();
		int unsigned threads;
		int unsigned depth;
		int unsigned base;
		int unsigned k;
		logic [3:0]  tid;
		logic [5:0]  init;
		threads = used_threads();
		depth   = ($urandom_range(9) < 8) ? threads : $urandom_range(threads - 1);
		base    = $urandom_range(threads - 1);
		for (k = 0; k < depth; k++) begin
			tid = 4'((base + k) % threads);
			send_item(CMD_THREAD_PASSIVE, tid, 1'($urandom), 6'($urandom), 6'($urandom));
			if ($urandom_range(19) == 0) begin
				send_item(CMD_THREAD_ACTIVE, tid, 1'($urandom), 6'($urandom), 6'($urandom));
				send_item(CMD_THREAD_PASSIVE, tid, 1'($urandom), 6'($urandom),
					6'($urandom));
			end
		end
		repeat ($urandom_range(2, 3)) begin
			init = 6'($urandom);
			send_item(CMD_TOKEN_IN, 4'($urandom), 1'($urandom_range(4) != 0), init,
				($urandom_range(4) < 3) ? init : 6'($urandom));
		end
		if ($urandom_range(2) == 0)
			send_item(CMD_SEND_TOKEN, 4'($urandom), 1'($urandom), 6'($urandom),
				6'($urandom));
		if ($urandom_range(9) == 0)
			send_item(CMD_TERM_IN, 4'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
		repeat ($urandom_range(2))
			send_item(CMD_THREAD_ACTIVE, 4'($urandom_range(threads - 1)), 1'($urandom),
				6'($urandom), 6'($urandom));
	endtask

	// Phases of random traffic, each under its own register setting. The
	// first three take the extremes; the rest mostly use small rings and few
	// threads, with the odd large or out-of-range value.
	task automatic test_random_rounds();
		int unsigned start;
		int unsigned phase_start;
		int unsigned phase;
		logic [5:0]  id;
		logic [6:0]  nodes;
		logic [4:0]  threads;
		start = counted_events;
		phase = 0;
		while (counted_events - start < RANDOM_EVENTS) begin
			case (phase)
				0: begin
					id      = 6'd63;
					nodes   = 7'd64;
					threads = 5'd16;
				end
				1: begin
					id      = 6'd0;
					nodes   = 7'd0;
					threads = 5'd0;
				end
				2: begin
					id      = 6'd0;
					nodes   = 7'd127;
					threads = 5'd31;
				end
				default: begin
					id      = ($urandom_range(2) == 0) ? 6'd0 : 6'($urandom);
					nodes   = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
					threads = ($urandom_range(5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4));
				end
			endcase
			configure(id, nodes, threads);
			phase_start = counted_events;
			while (counted_events - phase_start < PHASE_EVENTS &&
					counted_events - start < RANDOM_EVENTS) begin
				if ($urandom_range(9) < 7)
					run_round();
				else
					send_item(3'($urandom), 4'($urandom), 1'($urandom), 6'($urandom),
						6'($urandom));
			end
			phase++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		errors          = 0;
		cycle_count     = 0;
		events_sent     = 0;
		counted_events  = 0;
		results_checked = 0;
		broadcasts_seen = 0;
		settings_used   = 0;
		arst_n          = 1'b0;
		push            = 1'b0;
		cmd             = '0;
		worker_id       = '0;
		token_state     = 1'b0;
		token_initiator = '0;
		token_receiver  = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;

		// State after reset: node zero, one node, one thread, master.
		cfg_node_id      = 6'd0;
		cfg_node_count   = 7'd1;
		cfg_thread_count = 5'd1;
		wake_all_threads();
		sticky_idle     = 1'b0;
		holds_token     = 1'b1;
		terminated_seen = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_spare_codes_and_send();
		test_thread_activity();
		test_token_handling();
		test_wide_ring();
		test_random_rounds();

		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d events under %0d register settings: %0d results checked,",
			events_sent, settings_used + 1, results_checked);
		$display("including %0d complete terminator broadcasts.", broadcasts_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/trtd_pkg.sv
rtl/core/trtd_fifo.sv
rtl/core/trtd_front.sv
rtl/core/trtd_back.sv
rtl/core/token_ring_termination_detector_unit.sv
test/tb.sv
